### hdl/cdq_pkg.sv
// Shared types and constants for the circular deque core.
// Used by cdq_ctrl, cdq_datapath, circular_deque_core and the testbench; no dependencies.
package cdq_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 2;

    // Request codes (codes above REQ_POP_BACK act as a query)
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_EMIT
    } cdq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic fill;
        logic load_out;
    } cdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pop_fill;
        logic out_valid;
    } cdq_stat_t;

endpackage

### hdl/cdq_ctrl.sv
// Sequencer for the circular deque core: accept, optional refill, emit.
// Depends on cdq_pkg.
module cdq_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 m_tready,
    input  cdq_pkg::cdq_stat_t   stat,
    output cdq_pkg::cdq_cmd_t    cmd
);

    cdq_pkg::cdq_state_t state_reg;
    cdq_pkg::cdq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.fill     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            cdq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.pop_fill ? cdq_pkg::ST_FILL : cdq_pkg::ST_EMIT;
                end
            end
            cdq_pkg::ST_FILL:
            begin
                // take the registered slot read into front/back
                cmd.fill   = 1'b1;
                state_next = cdq_pkg::ST_EMIT;
            end
            cdq_pkg::ST_EMIT:
            begin
                // hold until the output register is free
                if (!stat.out_valid || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = cdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/cdq_datapath.sv
// Datapath of the circular deque core: slot memory, indices, count,
// cached front/back values and the output register. Depends on cdq_pkg.
module cdq_datapath
#(
    parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cdq_pkg::REQ_W-1:0]      req_type,
    input  logic [cdq_pkg::DATA_W-1:0]     push_value,
    input  cdq_pkg::cdq_cmd_t              cmd,
    output cdq_pkg::cdq_stat_t             stat,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [2*cdq_pkg::DATA_W-1:0]   m_tdata,
    output logic [cdq_pkg::STAT_W:0]       m_tuser
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [cdq_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [IDX_W-1:0]            head_reg, head_next;
    logic [IDX_W-1:0]            tail_reg, tail_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [cdq_pkg::DATA_W-1:0]  front_reg, front_next;
    logic [cdq_pkg::DATA_W-1:0]  back_reg, back_next;
    logic [cdq_pkg::DATA_W-1:0]  rd_data_reg;
    logic                        fill_front_reg, fill_front_next;
    logic [cdq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [2*cdq_pkg::DATA_W-1:0] out_data_reg;
    logic [cdq_pkg::STAT_W:0]    out_user_reg;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;

    logic                        is_push, is_pop, is_empty, is_full;
    logic [IDX_W-1:0]            head_inc, head_dec, tail_inc, tail_dec;

    assign is_push  = (req_type == cdq_pkg::REQ_PUSH_FRONT) ||
                      (req_type == cdq_pkg::REQ_PUSH_BACK);
    assign is_pop   = (req_type == cdq_pkg::REQ_POP_FRONT) ||
                      (req_type == cdq_pkg::REQ_POP_BACK);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);

    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - IDX_W'(1);
    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + IDX_W'(1);
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - IDX_W'(1);

    // a pop that leaves elements needs the new end slot read back
    assign stat.pop_fill  = is_pop && (count_reg > CNT_W'(1));
    assign stat.out_valid = out_valid_reg;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        fill_front_next = fill_front_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = head_reg;
        rd_en           = 1'b0;
        rd_addr         = head_inc;

        if (cmd.accept)
        begin
            status_next = cdq_pkg::STAT_DONE;
            if (is_push)
            begin
                if (is_full)
                begin
                    status_next = cdq_pkg::STAT_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (is_empty)
                    begin
                        tail_next  = head_reg;
                        wr_addr    = head_reg;
                        front_next = push_value;
                        back_next  = push_value;
                    end
                    else if (req_type == cdq_pkg::REQ_PUSH_FRONT)
                    begin
                        head_next  = head_dec;
                        wr_addr    = head_dec;
                        front_next = push_value;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                        back_next = push_value;
                    end
                end
            end
            else if (is_pop)
            begin
                if (is_empty)
                begin
                    status_next = cdq_pkg::STAT_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1))
                    begin
                        rd_en = 1'b1;
                        if (req_type == cdq_pkg::REQ_POP_FRONT)
                        begin
                            head_next       = head_inc;
                            rd_addr         = head_inc;
                            fill_front_next = 1'b1;
                        end
                        else
                        begin
                            tail_next       = tail_dec;
                            rd_addr         = tail_dec;
                            fill_front_next = 1'b0;
                        end
                    end
                end
            end
        end

        if (cmd.fill)
        begin
            if (fill_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                back_next = rd_data_reg;
            end
        end
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        fill_front_reg <= fill_front_next;
        status_reg     <= status_next;
        if (cmd.load_out)
        begin
            out_data_reg <= is_empty ? '0 : {back_reg, front_reg};
            out_user_reg <= {status_reg, is_empty};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### hdl/circular_deque_core.sv
// Circular deque core: top level joining cdq_ctrl and cdq_datapath.
// Sequence: query, push and refused requests go from accept straight to emit; a pop
// that leaves elements first refills the cached end value from the slot memory read.
// A new request is accepted only after the previous result word is loaded into the
// output register; emit waits while that register is full and m_tready is low.
// Reset (rst_n, async, active low) empties the deque; slot contents are not cleared.
module circular_deque_core
#(
    parameter int CAPACITY = cdq_pkg::DEF_CAPACITY
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdq_pkg::DATA_W-1:0]    s_tdata,   // [31:0] push_value
    input  logic [cdq_pkg::REQ_W-1:0]     s_tuser,   // [2:0] req_type
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*cdq_pkg::DATA_W-1:0]  m_tdata,   // [31:0] front_value, [63:32] back_value
    output logic [cdq_pkg::STAT_W:0]      m_tuser    // [0] is_empty, [2:1] status
);

    cdq_pkg::cdq_cmd_t  cmd;
    cdq_pkg::cdq_stat_t stat;

    // Controller: sequences accept, optional refill of a cached end value, and emit
    cdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: slot memory plus head/tail/count; front and back values are
    // cached in registers so only a pop needs a memory read
    cdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (s_tuser),
        .push_value (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // One request in flight: no accept right after an accept
    a_single_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another was in flight");

    // A new result word appears only while the input side is closed
    a_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result loaded while idle");

    // An empty deque reports zero front and back values
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("empty result carries data");

    // Refusals agree with the empty flag
    a_refusal_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2:1] != cdq_pkg::STAT_FULL || !m_tuser[0]) &&
                     (m_tuser[2:1] != cdq_pkg::STAT_EMPTY || m_tuser[0]))
        else $error("refusal status inconsistent with empty flag");

endmodule

### test/circular_deque_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_core: directed, fill-under-stall and random traffic.
// Depends on cdq_pkg and the circular_deque_core RTL; predicts each result word in place.
module circular_deque_core_tb;

    localparam int  DEPTH        = cdq_pkg::DEF_CAPACITY;
    localparam int  CLK_HALF_NS  = 10;
    localparam int  RESET_CYCLES = 8;
    localparam int  STALL_CYCLES = 400;   // long receiver hold-off; backs up the block
    localparam int  DRAIN_CYCLES = 12;    // extra wait after the last expected word, to catch strays
    localparam int  RANDOM_ITEMS = 560;
    localparam int  BIAS_BLOCK   = 40;    // words between changes of push/pop mix
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    // Highest request code the field can carry; codes above REQ_POP_BACK act as a query
    localparam logic [cdq_pkg::REQ_W-1:0] REQ_CODE_MAX = '1;

    // One result word as the block reports it
    typedef struct packed {
        logic [cdq_pkg::DATA_W-1:0] front;
        logic [cdq_pkg::DATA_W-1:0] back;
        logic                       empty;
        logic [cdq_pkg::STAT_W-1:0] status;
    } deque_view_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cdq_pkg::DATA_W-1:0]     s_tdata;    // [31:0] push_value
    logic [cdq_pkg::REQ_W-1:0]      s_tuser;    // [2:0] req_type
    logic                           m_tvalid;
    logic                           m_tready;
    logic [2*cdq_pkg::DATA_W-1:0]   m_tdata;    // [31:0] front_value, [63:32] back_value
    logic [cdq_pkg::STAT_W:0]       m_tuser;    // [0] is_empty, [2:1] status

    // Shadow of the deque: slots, front/back indices and occupancy
    logic [cdq_pkg::DATA_W-1:0]     shadow_slots [DEPTH];
    int                             shadow_head;
    int                             shadow_tail;
    int                             shadow_count;

    deque_view_t                    pending_views [$];
    int                             mismatch_count;

    // Idle percentages for each side; the receiver also serves long hold-offs
    int                             send_idle_pct;
    int                             recv_idle_pct;
    int                             stall_token;

    circular_deque_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        mismatch_count++;
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_val, got_val);
    endtask

    // Apply one accepted request to the shadow deque and queue the word it must produce
    task automatic predict_view(input logic [cdq_pkg::REQ_W-1:0] req,
                                input logic [cdq_pkg::DATA_W-1:0] val);
        deque_view_t view;
        view.status = cdq_pkg::STAT_DONE;
        case (req)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                    view.status = cdq_pkg::STAT_FULL;
                else
                begin
                    if (shadow_count == 0)
                    begin
                        // first element lands at head; no index moves
                        shadow_tail = shadow_head;
                        shadow_slots[shadow_head] = val;
                    end
                    else if (req == cdq_pkg::REQ_PUSH_FRONT)
                    begin
                        shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                        shadow_slots[shadow_head] = val;
                    end
                    else
                    begin
                        shadow_tail = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
                        shadow_slots[shadow_tail] = val;
                    end
                    shadow_count++;
                end
            end
            cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_BACK:
            begin
                if (shadow_count == 0)
                    view.status = cdq_pkg::STAT_EMPTY;
                else
                begin
                    // popping the last element leaves both indices in place
                    if (shadow_count > 1)
                    begin
                        if (req == cdq_pkg::REQ_POP_FRONT)
                            shadow_head = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
                        else
                            shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                    end
                    shadow_count--;
                end
            end
            default:
            begin
                // query and unused codes leave the deque untouched
            end
        endcase
        if (shadow_count == 0)
        begin
            view.front = '0;
            view.back  = '0;
            view.empty = 1'b1;
        end
        else
        begin
            view.front = shadow_slots[shadow_head];
            view.back  = shadow_slots[shadow_tail];
            view.empty = 1'b0;
        end
        pending_views.push_back(view);
    endtask

    // Offer one request word; idle first at the sender's rate, then hold until accepted
    task automatic send_request(input logic [cdq_pkg::REQ_W-1:0] req,
                                input logic [cdq_pkg::DATA_W-1:0] val);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= cdq_pkg::REQ_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_view(req, val);
    endtask

    // Drop valid after the last word of a sequence
    task automatic release_request_bus();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Mostly random values, with the sign and all-ones/all-zeros extremes mixed in
    function automatic logic [cdq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return {1'b1, {(cdq_pkg::DATA_W-1){1'b0}}};
            1:       return {1'b0, {(cdq_pkg::DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Wait for every expected word, then a little more to catch strays
    task automatic wait_for_drain();
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Refusals on empty, single-element push/pop, head index wrap at both ends of the slot range, unused codes
    task automatic test_directed_cases();
        logic [cdq_pkg::REQ_W-1:0] code;
        send_request(cdq_pkg::REQ_QUERY,      $urandom);
        send_request(cdq_pkg::REQ_POP_FRONT,  $urandom);
        send_request(cdq_pkg::REQ_POP_BACK,   $urandom);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(cdq_pkg::REQ_POP_BACK,   $urandom);
        send_request(cdq_pkg::REQ_PUSH_BACK,  32'h8000_0000);
        send_request(cdq_pkg::REQ_POP_FRONT,  $urandom);
        send_request(cdq_pkg::REQ_POP_FRONT,  $urandom);
        // head sits at slot 0: a front push into a non-empty deque wraps it to the top
        send_request(cdq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(cdq_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF);
        for (code = cdq_pkg::REQ_POP_BACK + 1'b1; code != '0; code++)
            send_request(code, $urandom);
        send_request(cdq_pkg::REQ_POP_FRONT,  $urandom);
        send_request(cdq_pkg::REQ_POP_FRONT,  $urandom);
        send_request(cdq_pkg::REQ_POP_BACK,   $urandom);
        send_request(cdq_pkg::REQ_QUERY,      32'hFFFF_FFFF);
        send_request(cdq_pkg::REQ_POP_BACK,   $urandom);
        send_request(cdq_pkg::REQ_POP_BACK,   $urandom);
        send_request(cdq_pkg::REQ_QUERY,      $urandom);
        release_request_bus();
        wait_for_drain();
    endtask

    // Hold off the receiver at the start, push past capacity, then drain past empty
    task automatic test_fill_under_stall();
        int n;
        stall_token++;
        for (n = 0; n < DEPTH + 6; n++)
            send_request(n[0] ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK, pick_value());
        send_request(cdq_pkg::REQ_QUERY, $urandom);
        for (n = 0; n < DEPTH + 4; n++)
            send_request(n[1] ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK, $urandom);
        release_request_bus();
        wait_for_drain();
    endtask

    // Random mix whose push/pop balance drifts block by block, so the fill level roams
    task automatic test_random_traffic(input int items);
        int n;
        int push_bias;
        int pick;
        logic [cdq_pkg::REQ_W-1:0] req;
        push_bias = 50;
        for (n = 0; n < items; n++)
        begin
            if (n % BIAS_BLOCK == 0)
                push_bias = $urandom_range(90, 10);
            pick = $urandom_range(99);
            if (pick < 6)
                req = $urandom_range(1) ? cdq_pkg::REQ_QUERY
                                        : cdq_pkg::REQ_W'($urandom_range(REQ_CODE_MAX,
                                                              cdq_pkg::REQ_POP_BACK + 1));
            else if ($urandom_range(99) < push_bias)
                req = $urandom_range(1) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK;
            else
                req = $urandom_range(1) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK;
            send_request(req, pick_value());
        end
        release_request_bus();
        wait_for_drain();
    endtask

    // Receiver: random ready at its idle rate, or a counted hold-off on request
    initial
    begin
        int stall_seen;
        int hold_left;
        stall_seen = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_token != stall_seen)
            begin
                stall_seen = stall_token;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        deque_view_t exp_view;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_views.size() == 0)
                report_mismatch("unexpected result word", 64'(0), 64'(m_tdata));
            else
            begin
                exp_view = pending_views.pop_front();
                if (m_tdata[cdq_pkg::DATA_W-1:0] !== exp_view.front)
                    report_mismatch("front_value", 64'(exp_view.front),
                                    64'(m_tdata[cdq_pkg::DATA_W-1:0]));
                if (m_tdata[2*cdq_pkg::DATA_W-1:cdq_pkg::DATA_W] !== exp_view.back)
                    report_mismatch("back_value", 64'(exp_view.back),
                                    64'(m_tdata[2*cdq_pkg::DATA_W-1:cdq_pkg::DATA_W]));
                if (m_tuser[0] !== exp_view.empty)
                    report_mismatch("is_empty", 64'(exp_view.empty), 64'(m_tuser[0]));
                if (m_tuser[cdq_pkg::STAT_W:1] !== exp_view.status)
                    report_mismatch("status", 64'(exp_view.status),
                                    64'(m_tuser[cdq_pkg::STAT_W:1]));
            end
        end
    end

    // Watchdog: end a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = cdq_pkg::REQ_QUERY;
        mismatch_count = 0;
        stall_token    = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        shadow_head    = 0;
        shadow_tail    = 0;
        shadow_count   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_fill_under_stall();

        // Sender busy, receiver mostly stalled; then swapped; then both flat out
        send_idle_pct = 13;
        recv_idle_pct = 71;
        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 71;
        recv_idle_pct = 13;
        test_random_traffic(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/cdq_pkg.sv
hdl/cdq_ctrl.sv
hdl/cdq_datapath.sv
hdl/circular_deque_core.sv
test/circular_deque_core_tb.sv
